@@ sv/mlta_pkg.sv @@
// Shared types and constants for the MAC learning table with aging.
package mlta_pkg;

    // Field widths fixed by the item format
    localparam int unsigned MAC_W  = 48;
    localparam int unsigned PORT_W = 4;
    localparam int unsigned TIME_W = 32;

    // Default table depth
    localparam int unsigned TABLE_ENTRIES_DEF = 64;

    // Item kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_LEARN  = 1'b1;

    // Configuration register map
    localparam int unsigned CFG_ADDR_W     = 3;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam logic        REG_IDX_LIFETIME = 1'b0;
    localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd300;

    typedef struct packed {
        logic              kind;
        logic [MAC_W-1:0]  mac_address;
        logic [PORT_W-1:0] ingress_port;
        logic [TIME_W-1:0] now;
    } t_request;

    typedef struct packed {
        logic              hit;
        logic [PORT_W-1:0] egress_port;
        logic              learn_dropped;
    } t_result;

endpackage

@@ sv/mlta_if.sv @@
// Valid/ready channel interfaces for request and result transfers.
interface mlta_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [mlta_pkg::MAC_W-1:0]    mac_address;
    logic [mlta_pkg::PORT_W-1:0]   ingress_port;
    logic [mlta_pkg::TIME_W-1:0]   now;

    modport source (output valid, kind, mac_address, ingress_port, now, input ready);
    modport sink   (input valid, kind, mac_address, ingress_port, now, output ready);
endinterface

interface mlta_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [mlta_pkg::PORT_W-1:0]   egress_port;
    logic                          learn_dropped;

    modport source (output valid, hit, egress_port, learn_dropped, input ready);
    modport sink   (input valid, hit, egress_port, learn_dropped, output ready);
endinterface

@@ sv/mlta_cfg.sv @@
// APB-style configuration register block holding the entry lifetime.
module mlta_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mlta_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mlta_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mlta_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [mlta_pkg::TIME_W-1:0]         o_lifetime
);

    logic [mlta_pkg::TIME_W-1:0] r_lifetime;
    logic                        sel_lifetime;

    // Decode the register index from the byte address
    assign sel_lifetime = (paddr[mlta_pkg::CFG_ADDR_W-1:2] == mlta_pkg::REG_IDX_LIFETIME);
    assign pready       = 1'b1;

    // Write on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= mlta_pkg::LIFETIME_RESET;
        end else if (psel && penable && pwrite && sel_lifetime) begin
            r_lifetime <= pwdata[mlta_pkg::TIME_W-1:0];
        end
    end

    // Read back; unmapped addresses return zero
    always_comb begin
        prdata = '0;
        if (sel_lifetime) begin
            prdata[mlta_pkg::TIME_W-1:0] = r_lifetime;
        end
    end

    assign o_lifetime = r_lifetime;

endmodule

@@ sv/mlta_cam.sv @@
// Associative table: parallel match, free-slot pick, learn and aging update.
module mlta_cam #(
    parameter int unsigned TABLE_ENTRIES = mlta_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  mlta_pkg::t_request            i_req,
    input  logic [mlta_pkg::TIME_W-1:0]   i_lifetime,
    output mlta_pkg::t_result             o_result
);

    // Table cells
    logic [TABLE_ENTRIES-1:0]        r_valid;
    logic [mlta_pkg::MAC_W-1:0]      r_mac    [TABLE_ENTRIES];
    logic [mlta_pkg::PORT_W-1:0]     r_port   [TABLE_ENTRIES];
    logic [mlta_pkg::TIME_W-1:0]     r_expiry [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0]        match;
    logic [TABLE_ENTRIES-1:0]        live;
    logic [TABLE_ENTRIES-1:0]        free;
    logic [TABLE_ENTRIES-1:0]        first_free;
    logic [TABLE_ENTRIES-1:0]        target;
    logic [TABLE_ENTRIES-1:0]        hit_vec;
    logic                            any_match;
    logic                            any_free;
    logic                            is_learn;
    logic [mlta_pkg::TIME_W:0]       expiry_sum;
    logic [mlta_pkg::TIME_W-1:0]     expiry_new;
    logic [mlta_pkg::PORT_W-1:0]     hit_port;

    assign is_learn = (i_req.kind == mlta_pkg::KIND_LEARN);

    // Compare every cell against the key and the current time
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_mac[i] == i_req.mac_address);
            live[i]  = r_expiry[i] > i_req.now;
            free[i]  = !r_valid[i] || !live[i];
        end
    end

    assign any_match  = |match;
    assign any_free   = |free;
    // Isolate the lowest free or expired slot
    assign first_free = free & (~free + TABLE_ENTRIES'(1));
    assign target     = any_match ? match : first_free;
    assign hit_vec    = match & live;

    // Saturate the new expiry at the top of the time range
    assign expiry_sum = {1'b0, i_req.now} + {1'b0, i_lifetime};
    assign expiry_new = expiry_sum[mlta_pkg::TIME_W] ? '1 : expiry_sum[mlta_pkg::TIME_W-1:0];

    // Gather the port of the live matching cell (at most one matches)
    always_comb begin
        hit_port = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_port = hit_port | (hit_vec[i] ? r_port[i] : '0);
        end
    end

    always_comb begin
        o_result               = '0;
        o_result.hit           = !is_learn && (|hit_vec);
        o_result.egress_port   = is_learn ? '0 : hit_port;
        o_result.learn_dropped = is_learn && !any_match && !any_free;
    end

    // Valid bits: set on learn, drop an expired entry found by lookup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_advance) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (is_learn && target[i]) begin
                    r_valid[i] <= 1'b1;
                end else if (!is_learn && match[i] && !live[i]) begin
                    r_valid[i] <= 1'b0;
                end
            end
        end
    end

    // Entry contents: write or refresh the target cell on learn
    always_ff @(posedge i_clk) begin
        if (i_advance && is_learn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (target[i]) begin
                    r_mac[i]    <= i_req.mac_address;
                    r_port[i]   <= i_req.ingress_port;
                    r_expiry[i] <= expiry_new;
                end
            end
        end
    end

endmodule

@@ sv/mac_learning_table_aging.sv @@
// Layer-2 learning table with aging: one result per request.
//
// Use: requests arrive on i_req (kind, mac_address, ingress_port, now).
// A learn writes or refreshes the entry for a source address with its port
// and an expiry of now plus the lifetime; a lookup returns the port of a
// live entry and removes an entry that has expired. Results leave on o_rsp
// (hit, egress_port, learn_dropped), one per request, in request order.
// The lifetime is set through the APB port at byte address 0.
// Pipeline: two register stages (input register, result register); a
// request passes through both before its result is offered.
// Throughput: one request per cycle while o_rsp is not stalled; the table
// compares all cells in parallel, combinationally between the two registers.
// Reset: the table empties, the lifetime returns to 300 and both channels
// hold no transfer. When the receiver stalls, the result register holds
// and one more request is taken into the input register before i_req.ready
// falls.
module mac_learning_table_aging #(
    parameter int unsigned TABLE_ENTRIES = mlta_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mlta_req_if.sink                            i_req,
    mlta_rsp_if.source                          o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mlta_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mlta_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mlta_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic                        r_in_valid;
    mlta_pkg::t_request          r_in;
    logic                        r_out_valid;
    mlta_pkg::t_result           r_out;
    logic                        advance;
    mlta_pkg::t_result           result;
    logic [mlta_pkg::TIME_W-1:0] lifetime;

    mlta_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_lifetime (lifetime)
    );

    mlta_cam #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_cam (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_req      (r_in),
        .i_lifetime (lifetime),
        .o_result   (result)
    );

    // Move the held request on when the result register is free or drains
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.kind         <= i_req.kind;
            r_in.mac_address  <= i_req.mac_address;
            r_in.ingress_port <= i_req.ingress_port;
            r_in.now          <= i_req.now;
        end
    end

    // Result register: load on advance, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out.hit;
    assign o_rsp.egress_port   = r_out.egress_port;
    assign o_rsp.learn_dropped = r_out.learn_dropped;

endmodule

@@ test/mac_learning_table_aging_tb.sv @@
// Self-checking testbench for the MAC learning table with aging.
module mac_learning_table_aging_tb;
    import mlta_pkg::*;

    localparam int unsigned TABLE_DEPTH  = TABLE_ENTRIES_DEF;
    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned POOL_MAX     = 128;
    localparam int unsigned REPORT_MAX   = 10;

    // Byte addresses: the lifetime register and an index that maps to nothing
    localparam logic [CFG_ADDR_W-1:0] LIFETIME_ADDR   = CFG_ADDR_W'(REG_IDX_LIFETIME) << 2;
    localparam logic [CFG_ADDR_W-1:0] UNUSED_REG_ADDR = CFG_ADDR_W'(1) << 2;

    localparam logic [MAC_W-1:0] MAC_ZERO  = '0;
    localparam logic [MAC_W-1:0] MAC_ONES  = '1;
    localparam logic [MAC_W-1:0] MAC_STEP  = 48'h0123_4567_89ab;
    localparam logic [MAC_W-1:0] MAC_CHECK = 48'ha5a5_5a5a_c3c3;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    mlta_req_if req_ch ();
    mlta_rsp_if rsp_ch ();

    mac_learning_table_aging dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the bridge table and its lifetime
    bit                tbl_valid  [TABLE_DEPTH];
    logic [MAC_W-1:0]  tbl_mac    [TABLE_DEPTH];
    logic [PORT_W-1:0] tbl_port   [TABLE_DEPTH];
    logic [TIME_W-1:0] tbl_expiry [TABLE_DEPTH];
    logic [TIME_W-1:0] table_lifetime;

    t_result           verdict_q[$];
    logic [MAC_W-1:0]  mac_pool [POOL_MAX];
    logic [TIME_W-1:0] wall_now;

    int src_idle_pct;
    int snk_idle_pct;
    int mismatch_count;
    int cycle_count;
    int requests_sent;
    int learns_sent;
    int verdicts_seen;
    int hits_seen;
    int drops_seen;
    int lifetime_writes;

    always #1 clk = ~clk;

    // Apply one request to the shadow table and return the forwarding verdict
    function automatic t_result table_apply(t_request r);
        int                slot;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] expiry;
        t_result           v;
        v    = '0;
        slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot < 0 && tbl_valid[i] && tbl_mac[i] == r.mac_address) slot = i;
        end
        if (r.kind == KIND_LEARN) begin
            sum    = {1'b0, r.now} + {1'b0, table_lifetime};
            expiry = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            // New address: take the lowest free or aged-out slot
            if (slot < 0) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot < 0 && (!tbl_valid[i] || tbl_expiry[i] <= r.now)) slot = i;
                end
            end
            if (slot < 0) begin
                v.learn_dropped = 1'b1;
            end else begin
                tbl_valid[slot]  = 1'b1;
                tbl_mac[slot]    = r.mac_address;
                tbl_port[slot]   = r.ingress_port;
                tbl_expiry[slot] = expiry;
            end
        end else if (slot >= 0) begin
            if (tbl_expiry[slot] > r.now) begin
                v.hit         = 1'b1;
                v.egress_port = tbl_port[slot];
            end else begin
                tbl_valid[slot] = 1'b0;
            end
        end
        return v;
    endfunction

    function automatic t_request make_request(logic k, logic [MAC_W-1:0] mac,
                                              logic [PORT_W-1:0] port, logic [TIME_W-1:0] t);
        t_request r;
        r.kind         = k;
        r.mac_address  = mac;
        r.ingress_port = port;
        r.now          = t;
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[MAC_W-1:0];
    endfunction

    // Append one expected verdict behind those still outstanding
    function automatic void queue_verdict(t_result v);
        verdict_q.insert(verdict_q.size(), v);
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
        if (mismatch_count < REPORT_MAX)
            $display("MISMATCH %s: expected 0x%0h, got 0x%0h (cycle %0d)",
                     what, want, got, cycle_count);
        mismatch_count++;
    endtask

    // Offer one request, with random idle cycles ahead of it, and log its verdict
    task automatic send_item(t_request r);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= r.kind;
        req_ch.mac_address  <= r.mac_address;
        req_ch.ingress_port <= r.ingress_port;
        req_ch.now          <= r.now;
        do @(posedge clk); while (!req_ch.ready);
        queue_verdict(table_apply(r));
        requests_sent++;
        if (r.kind == KIND_LEARN) learns_sent++;
    endtask

    // Stop offering and wait until every verdict is back
    task automatic drain_table();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == LIFETIME_ADDR) begin
            table_lifetime = data;
            lifetime_writes++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic lifetime_readback();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LIFETIME_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== table_lifetime)
            flag_mismatch("lifetime readback", 64'(table_lifetime), 64'(prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Set a new lifetime once the table is quiet, and move time forward
    task automatic start_phase(logic [TIME_W-1:0] lifetime, logic [TIME_W-1:0] now_floor);
        drain_table();
        cfg_write(LIFETIME_ADDR, lifetime);
        lifetime_readback();
        if (now_floor > wall_now) wall_now = now_floor;
    endtask

    // Mostly well-formed traffic over a pool of addresses, with monotonic time;
    // the rest is noise with unrelated addresses and arbitrary timestamps
    task automatic run_traffic(int n, int pool_n, int step_max, int learn_pct);
        logic [TIME_W:0] sum;
        logic            k;
        for (int i = 0; i < pool_n; i++) begin
            if ($urandom_range(1)) mac_pool[i] = random_mac();
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 10) begin
                send_item(make_request(1'($urandom_range(1)), random_mac(),
                                       PORT_W'($urandom_range(15)), $urandom()));
            end else begin
                sum      = {1'b0, wall_now} + (TIME_W + 1)'($urandom_range(step_max));
                wall_now = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                k        = ($urandom_range(99) < learn_pct) ? KIND_LEARN : KIND_LOOKUP;
                send_item(make_request(k, mac_pool[$urandom_range(pool_n - 1)],
                                       PORT_W'($urandom_range(15)), wall_now));
            end
        end
    endtask

    // Walk through refresh, expiry, removal, slot reuse, saturation and an unmapped write
    task automatic test_directed();
        lifetime_readback();
        send_item(make_request(KIND_LOOKUP, MAC_ZERO,  4'd0,  32'd0));
        send_item(make_request(KIND_LEARN,  MAC_ZERO,  4'd15, 32'd0));
        send_item(make_request(KIND_LEARN,  MAC_ONES,  4'd0,  32'd0));
        send_item(make_request(KIND_LOOKUP, MAC_ZERO,  4'd0,  32'd299));
        send_item(make_request(KIND_LOOKUP, MAC_ONES,  4'd0,  32'd299));
        send_item(make_request(KIND_LEARN,  MAC_ZERO,  4'd5,  32'd100));
        send_item(make_request(KIND_LOOKUP, MAC_ZERO,  4'd0,  32'd300));
        // aged-out entry on lookup: miss, then gone
        send_item(make_request(KIND_LOOKUP, MAC_ONES,  4'd0,  32'd300));
        send_item(make_request(KIND_LOOKUP, MAC_ONES,  4'd15, 32'd301));
        send_item(make_request(KIND_LEARN,  MAC_STEP,  4'd9,  32'd301));
        // free slot 0, then relearn an aged-out address that sits above it
        send_item(make_request(KIND_LOOKUP, MAC_ZERO,  4'd0,  32'd610));
        send_item(make_request(KIND_LEARN,  MAC_STEP,  4'd12, 32'd610));
        send_item(make_request(KIND_LEARN,  MAC_CHECK, 4'd7,  32'd610));
        send_item(make_request(KIND_LOOKUP, MAC_STEP,  4'd0,  32'd909));
        send_item(make_request(KIND_LOOKUP, MAC_CHECK, 4'd0,  32'd909));
        // maximum lifetime: expiry saturates
        start_phase(TIME_MAX, 32'd0);
        send_item(make_request(KIND_LEARN,  MAC_ONES,  4'd10, 32'd1000));
        send_item(make_request(KIND_LOOKUP, MAC_CHECK, 4'd0,  32'd1000));
        send_item(make_request(KIND_LOOKUP, MAC_ONES,  4'd0,  TIME_MAX - 1));
        send_item(make_request(KIND_LOOKUP, MAC_ONES,  4'd0,  TIME_MAX));
        // write to an unmapped index must leave the lifetime alone
        drain_table();
        cfg_write(UNUSED_REG_ADDR, 32'd7);
        lifetime_readback();
        start_phase(32'd0, 32'd0);
        send_item(make_request(KIND_LEARN,  MAC_ZERO,  4'd1,  TIME_MAX));
        send_item(make_request(KIND_LOOKUP, MAC_ZERO,  4'd0,  TIME_MAX));
        send_item(make_request(KIND_LEARN,  MAC_STEP,  4'd2,  32'd5));
        send_item(make_request(KIND_LOOKUP, MAC_STEP,  4'd0,  32'd5));
    endtask

    task automatic test_aging_mix(logic [TIME_W-1:0] lifetime);
        start_phase(lifetime, wall_now + 32'd1000);
        run_traffic(140, 40, 8, 50);
    endtask

    // More live addresses than slots: learns start to drop
    task automatic test_table_overflow();
        start_phase(32'd5000, wall_now + 32'd10000);
        run_traffic(140, 100, 2, 70);
    endtask

    task automatic test_instant_expiry(logic [TIME_W-1:0] lifetime);
        start_phase(lifetime, wall_now + 32'd10000);
        run_traffic(120, 14, 1, 50);
    endtask

    // Run time up to its ceiling with the widest lifetime
    task automatic test_saturating_expiry();
        start_phase(TIME_MAX, 32'hffff_ff00);
        run_traffic(60, 30, 9, 50);
    endtask

    // Result check: compare each transfer with the oldest outstanding verdict
    always @(posedge clk) begin
        t_result want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            verdicts_seen++;
            if (rsp_ch.hit === 1'b1) hits_seen++;
            if (rsp_ch.learn_dropped === 1'b1) drops_seen++;
            if (verdict_q.size() == 0) begin
                flag_mismatch("unrequested result", 64'd0, 64'd1);
            end else begin
                want = verdict_q.pop_front();
                if (rsp_ch.hit !== want.hit)
                    flag_mismatch("hit", 64'(want.hit), 64'(rsp_ch.hit));
                if (rsp_ch.egress_port !== want.egress_port)
                    flag_mismatch("egress_port", 64'(want.egress_port),
                                  64'(rsp_ch.egress_port));
                if (rsp_ch.learn_dropped !== want.learn_dropped)
                    flag_mismatch("learn_dropped", 64'(want.learn_dropped),
                                  64'(rsp_ch.learn_dropped));
            end
        end
    end

    // Randomly stall the result channel
    always @(negedge clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Watchdog: no finish within %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, verdict_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_LOOKUP;
        req_ch.mac_address  = '0;
        req_ch.ingress_port = '0;
        req_ch.now          = '0;
        rsp_ch.ready        = 1'b0;
        src_idle_pct        = 33;
        snk_idle_pct        = 48;
        mismatch_count      = 0;
        cycle_count         = 0;
        requests_sent       = 0;
        learns_sent         = 0;
        verdicts_seen       = 0;
        hits_seen           = 0;
        drops_seen          = 0;
        lifetime_writes     = 0;
        wall_now            = '0;
        table_lifetime      = LIFETIME_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < POOL_MAX; i++) mac_pool[i] = random_mac();

        // Hold reset, then release it
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();

        // Receiver-heavy idling, then sender-heavy, then none
        test_aging_mix(LIFETIME_RESET);
        test_table_overflow();
        test_instant_expiry(32'd0);

        src_idle_pct = 48;
        snk_idle_pct = 33;
        test_aging_mix($urandom_range(400, 10));
        test_table_overflow();
        test_instant_expiry(32'd1);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_aging_mix($urandom_range(32'h000f_ffff, 1));
        test_table_overflow();
        test_instant_expiry(32'd0);
        test_saturating_expiry();

        drain_table();
        $display("Covered %0d requests (%0d learns) over %0d lifetime settings",
                 requests_sent, learns_sent, lifetime_writes);
        $display("Checked %0d results: %0d hits, %0d dropped learns, %0d mismatches",
                 verdicts_seen, hits_seen, drops_seen, mismatch_count);
        if (mismatch_count == 0 && verdict_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
